// File: src/acsn_pkg.sv
// ----------------------------------------------------------------------------
// acsn_pkg: shared types and constants for the sensor normalizer
// Frame and result payloads, lane status, lane states and bound reset values.
// ----------------------------------------------------------------------------
package acsn_pkg;

  localparam int unsigned CHANNELS    = 8;
  localparam int unsigned HALF        = CHANNELS / 2;
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned LEVEL_W     = 7;
  localparam int unsigned HALF_SUM_W  = 9;
  localparam int unsigned TOTAL_SUM_W = 10;
  localparam int unsigned NUM_W       = SAMPLE_W + LEVEL_W;
  localparam int unsigned CNT_W       = 3;

  localparam logic [LEVEL_W-1:0]  SCALE     = 7'd100;
  localparam logic [SAMPLE_W-1:0] MIN_RESET = 12'd120;
  localparam logic [CNT_W-1:0]    LAST_STEP = 3'(LEVEL_W - 1);

  // lane control states
  typedef enum logic [1:0] {
    LANE_IDLE,
    LANE_LOAD,
    LANE_DIV,
    LANE_DONE
  } lane_state_e;

  // one frame of eight samples
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_front_left_parallel;
    logic [SAMPLE_W-1:0] sample_front_left_vertical;
    logic [SAMPLE_W-1:0] sample_front_right_vertical;
    logic [SAMPLE_W-1:0] sample_front_right_parallel;
    logic [SAMPLE_W-1:0] sample_back_left_parallel;
    logic [SAMPLE_W-1:0] sample_back_left_vertical;
    logic [SAMPLE_W-1:0] sample_back_right_vertical;
    logic [SAMPLE_W-1:0] sample_back_right_parallel;
  } frame_t;

  // normalized levels and field sums
  typedef struct packed {
    logic [LEVEL_W-1:0]     level_front_left_parallel;
    logic [LEVEL_W-1:0]     level_front_left_vertical;
    logic [LEVEL_W-1:0]     level_front_right_vertical;
    logic [LEVEL_W-1:0]     level_front_right_parallel;
    logic [LEVEL_W-1:0]     level_back_left_parallel;
    logic [LEVEL_W-1:0]     level_back_left_vertical;
    logic [LEVEL_W-1:0]     level_back_right_vertical;
    logic [LEVEL_W-1:0]     level_back_right_parallel;
    logic [HALF_SUM_W-1:0]  front_field_sum;
    logic [HALF_SUM_W-1:0]  back_field_sum;
    logic [TOTAL_SUM_W-1:0] total_field_sum;
  } result_t;

  // what a lane reports to the merge stage
  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] level;
  } lane_stat_t;

  // maximum bound after reset, by channel
  function automatic logic [SAMPLE_W-1:0] max_reset(input int unsigned ch);
    logic [SAMPLE_W-1:0] val;
    case (ch)
      1:       val = 12'd2300;
      2, 3:    val = 12'd999;
      default: val = 12'd2500;
    endcase
    return val;
  endfunction

endpackage

// File: src/acsn_if.sv
// ----------------------------------------------------------------------------
// acsn_if: valid/ready channels of the sensor normalizer
// Frame channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface acsn_frame_if;
  import acsn_pkg::*;

  logic   valid;
  logic   ready;
  frame_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acsn_result_if;
  import acsn_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/acsn_lane.sv
// ----------------------------------------------------------------------------
// acsn_lane: one channel of the normalizer
// Tracks the running min/max of its channel and scales the sample to percent
// with a restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acsn_lane #(
  parameter int unsigned LaneIdx = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [acsn_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          take_i,
  output acsn_pkg::lane_stat_t          stat_o
);
  import acsn_pkg::*;

  lane_state_e         state_q, state_d;
  logic [SAMPLE_W-1:0] min_q, min_d;
  logic [SAMPLE_W-1:0] max_q, max_d;
  logic [SAMPLE_W-1:0] sample_q;
  logic [NUM_W-1:0]    num_q, num_d;
  logic [NUM_W-1:0]    den_q, den_d;
  logic [LEVEL_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SAMPLE_W-1:0] diff;
  logic [SAMPLE_W-1:0] span;
  logic                fits;

  assign diff = sample_q - min_q;
  assign span = max_q - min_q;
  assign fits = (num_q >= den_q);

  // next state, bound update and divider step
  always_comb begin
    state_d = state_q;
    min_d   = min_q;
    max_d   = max_q;
    num_d   = num_q;
    den_d   = den_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      LANE_IDLE: begin
        if (start_i) begin
          if (sample_i < min_q) begin
            min_d = sample_i;
          end else if (sample_i > max_q) begin
            max_d = sample_i;
          end
          state_d = LANE_LOAD;
        end
      end
      LANE_LOAD: begin
        // numerator (s - min) * 100, divisor aligned to the top quotient bit
        num_d = NUM_W'({{LEVEL_W{1'b0}}, diff} * {{SAMPLE_W{1'b0}}, SCALE});
        if (max_q <= min_q) begin
          // empty span reads as level zero
          num_d = '0;
          den_d = '1;
        end else begin
          den_d = {1'b0, span, {(LEVEL_W - 1){1'b0}}};
        end
        quo_d   = '0;
        cnt_d   = '0;
        state_d = LANE_DIV;
      end
      LANE_DIV: begin
        if (fits) begin
          num_d = num_q - den_q;
        end
        quo_d = {quo_q[LEVEL_W-2:0], fits};
        den_d = den_q >> 1;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == LAST_STEP) begin
          state_d = LANE_DONE;
        end
      end
      LANE_DONE: begin
        if (take_i) begin
          state_d = LANE_IDLE;
        end
      end
      default: state_d = LANE_IDLE;
    endcase
  end

  // control and bound registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LANE_IDLE;
      min_q   <= MIN_RESET;
      max_q   <= max_reset(LaneIdx);
    end else begin
      state_q <= state_d;
      min_q   <= min_d;
      max_q   <= max_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == LANE_IDLE && start_i) begin
      sample_q <= sample_i;
    end
    num_q <= num_d;
    den_q <= den_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
  end

  assign stat_o.done  = (state_q == LANE_DONE);
  assign stat_o.level = quo_q;

endmodule

// File: src/acsn_merge.sv
// ----------------------------------------------------------------------------
// acsn_merge: merging stage of the normalizer
// Sums the lane levels into front, back and total and holds the result word
// in the output register until it is taken.
// ----------------------------------------------------------------------------
module acsn_merge (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        load_i,
  input  logic [acsn_pkg::CHANNELS-1:0][acsn_pkg::LEVEL_W-1:0] level_i,
  input  logic                                        ready_i,
  output logic                                        valid_o,
  output acsn_pkg::result_t                           res_o,
  output logic                                        free_o
);
  import acsn_pkg::*;

  logic                   valid_q;
  result_t                res_q, res_d;
  logic [HALF_SUM_W-1:0]  front;
  logic [HALF_SUM_W-1:0]  back;

  // front and back field sums
  always_comb begin
    front = '0;
    back  = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (i < HALF) begin
        front = front + HALF_SUM_W'(level_i[i]);
      end else begin
        back = back + HALF_SUM_W'(level_i[i]);
      end
    end
  end

  // result word
  always_comb begin
    res_d.level_front_left_parallel  = level_i[0];
    res_d.level_front_left_vertical  = level_i[1];
    res_d.level_front_right_vertical = level_i[2];
    res_d.level_front_right_parallel = level_i[3];
    res_d.level_back_left_parallel   = level_i[4];
    res_d.level_back_left_vertical   = level_i[5];
    res_d.level_back_right_vertical  = level_i[6];
    res_d.level_back_right_parallel  = level_i[7];
    res_d.front_field_sum            = front;
    res_d.back_field_sum             = back;
    res_d.total_field_sum            = TOTAL_SUM_W'(front) + TOTAL_SUM_W'(back);
  end

  assign free_o = !valid_q || ready_i;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: src/auto_calibrating_sensor_normalizer_top.sv
// ----------------------------------------------------------------------------
// auto_calibrating_sensor_normalizer_top: running min/max sensor normalizer
// Eight channel lanes scale one frame to percent levels; a merge stage adds
// the front, back and total field sums.
//
//   channel   dir  handshake    word
//   frame_i   in   valid/ready  eight 12-bit coil samples
//   result_o  out  valid/ready  eight 7-bit levels and three sums
//
// A result word follows its frame through these steps: the bounds update on
// the accepting edge, then the scale multiply, the per-lane divider (one
// quotient bit per cycle) and the load of the output register. The next
// frame can be accepted in the cycle after that load. One frame is in the
// lanes at a time; the next is accepted once the result has moved to the
// output register, even while that word is still waiting. A stalled result
// holds the lanes in their done state. Reset loads the calibration bounds
// at once.
// ----------------------------------------------------------------------------
module auto_calibrating_sensor_normalizer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  acsn_frame_if.sink    frame_i,
  acsn_result_if.source result_o
);
  import acsn_pkg::*;

  logic                              busy_q;
  logic                              accept;
  logic                              load;
  logic                              out_free;
  logic [CHANNELS-1:0]               done;
  logic [CHANNELS-1:0][SAMPLE_W-1:0] samples;
  logic [CHANNELS-1:0][LEVEL_W-1:0]  levels;
  lane_stat_t [CHANNELS-1:0]         stat;

  assign frame_i.ready = !busy_q;
  assign accept        = frame_i.valid && !busy_q;
  assign load          = (&done) && out_free;

  // frame fields in channel order
  assign samples[0] = frame_i.data.sample_front_left_parallel;
  assign samples[1] = frame_i.data.sample_front_left_vertical;
  assign samples[2] = frame_i.data.sample_front_right_vertical;
  assign samples[3] = frame_i.data.sample_front_right_parallel;
  assign samples[4] = frame_i.data.sample_back_left_parallel;
  assign samples[5] = frame_i.data.sample_back_left_vertical;
  assign samples[6] = frame_i.data.sample_back_right_vertical;
  assign samples[7] = frame_i.data.sample_back_right_parallel;

  // channel lanes
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    acsn_lane #(
      .LaneIdx(g)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (accept),
      .sample_i(samples[g]),
      .take_i  (load),
      .stat_o  (stat[g])
    );
    assign done[g]   = stat[g].done;
    assign levels[g] = stat[g].level;
  end

  // merging stage and output register
  acsn_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .level_i(levels),
    .ready_i(result_o.ready),
    .valid_o(result_o.valid),
    .res_o  (result_o.data),
    .free_o (out_free)
  );

  // busy from frame acceptance until the result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (load) begin
      busy_q <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  // lanes run in lockstep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done[0] |-> &done)
    else $error("lanes finished out of step");

  // lanes only finish on an accepted frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done[0] |-> busy_q)
    else $error("lane done while block idle");

  // a new result word only follows a frame in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(busy_q))
    else $error("result without a frame");

  // total is the sum of the halves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.data.total_field_sum ==
      TOTAL_SUM_W'(result_o.data.front_field_sum) +
      TOTAL_SUM_W'(result_o.data.back_field_sum)))
    else $error("total sum mismatch");
`endif

endmodule
